>>> rtl/drn_pkg.sv
// Types, symbol codes and digit pattern tables shared by the Roman numeral converter.
package drn_pkg;

   localparam int NumberWidth = 12;
   localparam int SymbolWidth = 7;
   localparam int Places = 4;
   localparam logic [NumberWidth-1:0] MaxValid = 12'd3999;

   localparam logic [SymbolWidth-1:0] SymI = 7'h49;
   localparam logic [SymbolWidth-1:0] SymV = 7'h56;
   localparam logic [SymbolWidth-1:0] SymX = 7'h58;
   localparam logic [SymbolWidth-1:0] SymL = 7'h4C;
   localparam logic [SymbolWidth-1:0] SymC = 7'h43;
   localparam logic [SymbolWidth-1:0] SymD = 7'h44;
   localparam logic [SymbolWidth-1:0] SymM = 7'h4D;
   localparam logic [SymbolWidth-1:0] SymNone = 7'h00;

   typedef enum logic [1:0] {
      CODE_ONE,
      CODE_FIVE,
      CODE_TEN
   } code_type;

   typedef struct packed {
      logic             err;
      logic [3:0][3:0]  digit;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [2:0] digit_length(input logic [3:0] d);
      logic [2:0] len;
      case (d)
         4'd0: len = 3'd0;
         4'd1: len = 3'd1;
         4'd2: len = 3'd2;
         4'd3: len = 3'd3;
         4'd4: len = 3'd2;
         4'd5: len = 3'd1;
         4'd6: len = 3'd2;
         4'd7: len = 3'd3;
         4'd8: len = 3'd4;
         default: len = 3'd2;
      endcase
      return len;
   endfunction

   function automatic code_type digit_code(input logic [3:0] d, input logic [1:0] pos);
      code_type code;
      case (d)
         4'd0, 4'd1, 4'd2, 4'd3: code = CODE_ONE;
         4'd4: code = (pos == 2'd0) ? CODE_ONE : CODE_FIVE;
         4'd5, 4'd6, 4'd7, 4'd8: code = (pos == 2'd0) ? CODE_FIVE : CODE_ONE;
         default: code = (pos == 2'd0) ? CODE_ONE : CODE_TEN;
      endcase
      return code;
   endfunction

   function automatic logic [SymbolWidth-1:0] place_symbol(input logic [1:0] place,
                                                           input code_type code);
      logic [SymbolWidth-1:0] sym;
      case (place)
         2'd0: sym = (code == CODE_ONE) ? SymI : (code == CODE_FIVE) ? SymV : SymX;
         2'd1: sym = (code == CODE_ONE) ? SymX : (code == CODE_FIVE) ? SymL : SymC;
         2'd2: sym = (code == CODE_ONE) ? SymC : (code == CODE_FIVE) ? SymD : SymM;
         default: sym = (code == CODE_ONE) ? SymM : SymNone;
      endcase
      return sym;
   endfunction

endpackage

>>> rtl/drn_front.sv
// Front end: accepts a number, checks its range and splits it into decimal digits.
module drn_front import drn_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [NumberWidth-1:0] req_number,
   output logic                   busy,
   input  queue_status_type       q_status,
   output logic                   push,
   output entry_type              push_entry
);

   logic                   valid_ff, valid_in;
   logic [NumberWidth-1:0] number_ff;
   logic                   accept;

   logic [1:0]  thousands;
   logic [9:0]  rem1;
   logic [3:0]  hundreds;
   logic [6:0]  rem2;
   logic [3:0]  tens;
   logic [3:0]  units;
   logic [NumberWidth-1:0] rem1_wide;
   logic [9:0]  rem2_wide;

   assign busy = valid_ff && q_status.full;
   assign accept = start && !busy;
   assign push = valid_ff && !q_status.full;
   assign valid_in = accept || (valid_ff && !push);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         number_ff <= req_number;
      end
   end

   always_comb begin
      thousands = 2'd0;
      for (int k = 1; k < 4; k++) begin
         if (number_ff >= NumberWidth'(k * 1000)) begin
            thousands = 2'(k);
         end
      end
      rem1_wide = number_ff - NumberWidth'(thousands) * NumberWidth'(1000);
      rem1 = rem1_wide[9:0];

      hundreds = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (rem1 >= 10'(k * 100)) begin
            hundreds = 4'(k);
         end
      end
      rem2_wide = rem1 - 10'(hundreds) * 10'd100;
      rem2 = rem2_wide[6:0];

      tens = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (rem2 >= 7'(k * 10)) begin
            tens = 4'(k);
         end
      end
      units = 4'(rem2 - 7'(tens) * 7'd10);
   end

   always_comb begin
      push_entry.err = (number_ff == '0) || (number_ff > MaxValid);
      push_entry.digit[3] = {2'b00, thousands};
      push_entry.digit[2] = hundreds;
      push_entry.digit[1] = tens;
      push_entry.digit[0] = units;
   end

endmodule

>>> rtl/drn_queue.sv
// Two-entry queue of digit words between the front end and the character sequencer.
module drn_queue import drn_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        head,
   output queue_status_type q_status
);

   entry_type  slots_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign head = slots_ff[rd_ptr_ff];
   assign q_status.full = (count_ff == 2'd2);
   assign q_status.empty = (count_ff == 2'd0);

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> rtl/drn_back.sv
// Back end: walks the digits of one word and emits one Roman character per cycle.
module drn_back import drn_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  queue_status_type       q_status,
   input  entry_type              head,
   output logic                   pop,
   output logic                   rsp_valid,
   output logic [SymbolWidth-1:0] rsp_symbol,
   output logic                   rsp_last,
   output logic                   rsp_out_of_range
);

   logic       active_ff, active_in;
   entry_type  entry_ff;
   logic [1:0] place_ff, place_in;
   logic [1:0] pos_ff, pos_in;

   logic                   valid_ff;
   logic [SymbolWidth-1:0] symbol_ff;
   logic                   last_ff;
   logic                   err_ff;

   logic [3:0]             cur_digit;
   logic [2:0]             cur_len;
   logic                   digit_done;
   logic                   has_lower;
   logic [1:0]             next_place;
   logic [1:0]             start_place;
   logic                   last;
   logic [SymbolWidth-1:0] symbol;

   always_comb begin
      cur_digit = entry_ff.digit[place_ff];
      cur_len = digit_length(cur_digit);
      digit_done = ({1'b0, pos_ff} + 3'd1) >= cur_len;
      has_lower = 1'b0;
      next_place = 2'd0;
      for (int i = 0; i < Places - 1; i++) begin
         if ((2'(i) < place_ff) && (entry_ff.digit[i] != 4'd0)) begin
            has_lower = 1'b1;
            next_place = 2'(i);
         end
      end
      start_place = 2'd0;
      for (int i = 0; i < Places; i++) begin
         if (head.digit[i] != 4'd0) begin
            start_place = 2'(i);
         end
      end
      last = entry_ff.err || (digit_done && !has_lower);
      symbol = entry_ff.err ? SymNone : place_symbol(place_ff, digit_code(cur_digit, pos_ff));

      pop = !q_status.empty && (!active_ff || last);
      active_in = pop || (active_ff && !last);

      if (pop) begin
         place_in = start_place;
         pos_in = 2'd0;
      end else if (digit_done) begin
         place_in = next_place;
         pos_in = 2'd0;
      end else begin
         place_in = place_ff;
         pos_in = pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff <= active_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         entry_ff <= head;
      end
      place_ff <= place_in;
      pos_ff <= pos_in;
      symbol_ff <= symbol;
      last_ff <= last;
      err_ff <= entry_ff.err;
   end

   assign rsp_valid = valid_ff;
   assign rsp_symbol = symbol_ff;
   assign rsp_last = last_ff;
   assign rsp_out_of_range = err_ff;

endmodule

>>> rtl/decimal_to_roman_numeral_unit.sv
// Top level of the decimal to Roman numeral converter.
// A number is taken when start is high and busy is low; it is split into decimal digits in the
// front stage, waits in a two-word queue, and the back end then emits the numeral one ASCII
// character per cycle on rsp_symbol with rsp_valid high, marking the final character with
// rsp_last. A numeral has 1 to 15 characters and the back end produces exactly one character per
// cycle; numerals follow each other without gaps while the queue holds the next word.
// A number reaches the output via the front register, a queue slot, the word and output registers.
// A number of 0 or above 3999 gives one word with symbol 0, rsp_last and rsp_out_of_range set.
// The receiver cannot stall; busy rises only while the queue is full and the front stage holds
// a word.
module decimal_to_roman_numeral_unit import drn_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [NumberWidth-1:0] req_number,
   output logic                   busy,
   output logic                   rsp_valid,
   output logic [SymbolWidth-1:0] rsp_symbol,
   output logic                   rsp_last,
   output logic                   rsp_out_of_range
);

   queue_status_type q_status;
   logic             push;
   logic             pop;
   entry_type        push_entry;
   entry_type        head;

   drn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_number (req_number),
      .busy       (busy),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   drn_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_status   (q_status)
   );

   drn_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_symbol       (rsp_symbol),
      .rsp_last         (rsp_last),
      .rsp_out_of_range (rsp_out_of_range)
   );

   assert property (@(posedge clock) disable iff (reset) push |-> !q_status.full)
      else $error("Queue written while full.");

   assert property (@(posedge clock) disable iff (reset) pop |-> !q_status.empty)
      else $error("Queue read while empty.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |-> (rsp_last && (rsp_symbol == SymNone)))
      else $error("Range error word is not a single zero character.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_out_of_range) |-> (rsp_symbol != SymNone))
      else $error("Valid numeral carries a zero character.");

endmodule

>>> bench/tb_decimal_to_roman_numeral_unit.sv
// Self-checking testbench for the decimal to Roman numeral converter.
module tb_decimal_to_roman_numeral_unit import drn_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DirectedCount = 25;
   localparam int RandomCount = 325;
   localparam int CalmTail = 60;
   localparam int DrainLimit = 5000;

   typedef struct packed {
      logic [SymbolWidth-1:0] symbol;
      logic                   last;
      logic                   out_of_range;
   } char_word_type;

   typedef struct packed {
      logic [NumberWidth-1:0] number;
      logic                   typed;
      logic [SymbolWidth-1:0] symbol;
      logic                   out_of_range;
   } stimulus_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic [NumberWidth-1:0] req_number = '0;
   logic                   busy;
   logic                   rsp_valid;
   logic [SymbolWidth-1:0] rsp_symbol;
   logic                   rsp_last;
   logic                   rsp_out_of_range;

   char_word_type pending_chars[$];
   int            mismatch_count = 0;
   int            chars_checked = 0;
   int            numbers_sent = 0;
   int            range_errors_sent = 0;
   bit            idling_on = 1'b1;

   logic [SymbolWidth-1:0] one_sym[Places] = '{SymI, SymX, SymC, SymM};
   logic [SymbolWidth-1:0] five_sym[Places] = '{SymV, SymL, SymD, SymNone};
   logic [SymbolWidth-1:0] ten_sym[Places] = '{SymX, SymC, SymM, SymNone};

   stimulus_row_type directed_rows[DirectedCount] = '{
      '{12'd0,    1'b1, SymNone, 1'b1},
      '{12'd4095, 1'b1, SymNone, 1'b1},
      '{12'd4000, 1'b1, SymNone, 1'b1},
      '{12'd4094, 1'b1, SymNone, 1'b1},
      '{12'd1,    1'b1, SymI,    1'b0},
      '{12'd5,    1'b1, SymV,    1'b0},
      '{12'd10,   1'b1, SymX,    1'b0},
      '{12'd50,   1'b1, SymL,    1'b0},
      '{12'd100,  1'b1, SymC,    1'b0},
      '{12'd500,  1'b1, SymD,    1'b0},
      '{12'd1000, 1'b1, SymM,    1'b0},
      '{12'd3999, 1'b0, SymNone, 1'b0},
      '{12'd3888, 1'b0, SymNone, 1'b0},
      '{12'd800,  1'b0, SymNone, 1'b0},
      '{12'd4,    1'b0, SymNone, 1'b0},
      '{12'd9,    1'b0, SymNone, 1'b0},
      '{12'd40,   1'b0, SymNone, 1'b0},
      '{12'd90,   1'b0, SymNone, 1'b0},
      '{12'd400,  1'b0, SymNone, 1'b0},
      '{12'd900,  1'b0, SymNone, 1'b0},
      '{12'd444,  1'b0, SymNone, 1'b0},
      '{12'd1994, 1'b0, SymNone, 1'b0},
      '{12'd2048, 1'b0, SymNone, 1'b0},
      '{12'd2730, 1'b0, SymNone, 1'b0},
      '{12'd1365, 1'b0, SymNone, 1'b0}
   };

   decimal_to_roman_numeral_unit DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_number(req_number),
      .busy(busy),
      .rsp_valid(rsp_valid),
      .rsp_symbol(rsp_symbol),
      .rsp_last(rsp_last),
      .rsp_out_of_range(rsp_out_of_range)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Spells one number as Roman characters and queues them as expected words.
   function automatic void spell_roman(input logic [NumberWidth-1:0] n);
      logic [SymbolWidth-1:0] chars[16];
      int                     digit[Places];
      int                     count;
      int                     rest;
      char_word_type          word;
      count = 0;
      if (n == 0 || n > MaxValid) begin
         word.symbol = SymNone;
         word.last = 1'b1;
         word.out_of_range = 1'b1;
         pending_chars.push_back(word);
         return;
      end
      rest = int'(n);
      digit[3] = rest / 1000;
      rest = rest % 1000;
      digit[2] = rest / 100;
      rest = rest % 100;
      digit[1] = rest / 10;
      digit[0] = rest % 10;
      for (int p = Places - 1; p >= 0; p--) begin
         if (digit[p] == 9) begin
            chars[count] = one_sym[p];
            chars[count + 1] = ten_sym[p];
            count += 2;
         end else if (digit[p] == 4) begin
            chars[count] = one_sym[p];
            chars[count + 1] = five_sym[p];
            count += 2;
         end else begin
            if (digit[p] >= 5) begin
               chars[count] = five_sym[p];
               count++;
            end
            for (int k = 0; k < digit[p] % 5; k++) begin
               chars[count] = one_sym[p];
               count++;
            end
         end
      end
      for (int k = 0; k < count; k++) begin
         word.symbol = chars[k];
         word.last = (k == count - 1);
         word.out_of_range = 1'b0;
         pending_chars.push_back(word);
      end
   endfunction

   task automatic send_number(input logic [NumberWidth-1:0] n, input logic typed,
                              input logic [SymbolWidth-1:0] symbol, input logic oor);
      char_word_type word;
      start <= 1'b1;
      req_number <= n;
      do @(posedge clock); while (!(start && !busy));
      if (typed) begin
         word.symbol = symbol;
         word.last = 1'b1;
         word.out_of_range = oor;
         pending_chars.push_back(word);
      end else begin
         spell_roman(n);
      end
      numbers_sent++;
      if (n == 0 || n > MaxValid) range_errors_sent++;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   function automatic logic [NumberWidth-1:0] pick_number();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 82) return NumberWidth'($urandom_range(1, 3999));
      if (sel < 88) return '0;
      if (sel < 95) return NumberWidth'($urandom_range(4000, 4095));
      return NumberWidth'($urandom);
   endfunction

   always @(posedge clock) begin
      char_word_type want;
      if (!reset && rsp_valid) begin
         chars_checked++;
         if (pending_chars.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected word: symbol %h last %b out_of_range %b",
                        rsp_symbol, rsp_last, rsp_out_of_range);
         end else begin
            want = pending_chars.pop_front();
            if (rsp_symbol !== want.symbol || rsp_last !== want.last ||
                rsp_out_of_range !== want.out_of_range) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected symbol %h last %b out_of_range %b, got %h %b %b",
                           want.symbol, want.last, want.out_of_range,
                           rsp_symbol, rsp_last, rsp_out_of_range);
            end
         end
      end
   end

   initial begin
      int guard;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < DirectedCount; i++)
         send_number(directed_rows[i].number, directed_rows[i].typed,
                     directed_rows[i].symbol, directed_rows[i].out_of_range);
      for (int i = 0; i < RandomCount; i++) begin
         if (i == RandomCount / 2) begin
            start <= 1'b0;
            while (pending_chars.size() != 0) @(posedge clock);
         end
         if (i == RandomCount - CalmTail) idling_on = 1'b0;
         send_number(pick_number(), 1'b0, SymNone, 1'b0);
      end
      start <= 1'b0;
      guard = 0;
      while (pending_chars.size() != 0 && guard < DrainLimit) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
      if (pending_chars.size() != 0) begin
         mismatch_count++;
         $display("%0d expected words never arrived", pending_chars.size());
      end
      $display("Converted %0d numbers, %0d of them out of range, and checked %0d characters.",
               numbers_sent, range_errors_sent, chars_checked);
      $display("Mismatches found: %0d.", mismatch_count);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

>>> files.f
rtl/drn_pkg.sv
rtl/drn_front.sv
rtl/drn_queue.sv
rtl/drn_back.sv
rtl/decimal_to_roman_numeral_unit.sv
bench/tb_decimal_to_roman_numeral_unit.sv
